>>> src/bmpenc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpenc_pkg
// Shared types, constants and helpers of the 24-bit BMP stream encoder.
// ----------------------------------------------------------------------------
package bmpenc_pkg;

  localparam int DIM_BITS = 14;
  localparam int DIM_W    = DIM_BITS + 1;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 2;
  localparam int STRIDE_W = DIM_W + 2;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = 6;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W    = $clog2(FIFO_DEPTH);
  localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);
  localparam logic [CFG_W-1:0] DIM_MAX    = CFG_W'(1) << DIM_BITS;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  localparam logic [IDX_W-1:0] HDR_LEN   = IDX_W'(54);
  localparam logic [IDX_W-1:0] HDR_LAST  = IDX_W'(53);
  localparam logic [IDX_W-1:0] HDR_WORD0 = IDX_W'(2);
  localparam logic [IDX_W-1:0] PIX_LAST  = IDX_W'(2);

  localparam logic [WORD_W-1:0] DIB_LEN      = WORD_W'(40);
  localparam logic [WORD_W-1:0] PELS_PER_M   = WORD_W'(3780);
  localparam logic [WORD_W-1:0] PLANES_BPP   = 32'h0018_0001;

  // 4-byte header slots, counted from byte offset 2
  localparam logic [3:0] HW_FSIZE  = 4'd0;
  localparam logic [3:0] HW_OFFSET = 4'd2;
  localparam logic [3:0] HW_DIB    = 4'd3;
  localparam logic [3:0] HW_WIDTH  = 4'd4;
  localparam logic [3:0] HW_HEIGHT = 4'd5;
  localparam logic [3:0] HW_PLANES = 4'd6;
  localparam logic [3:0] HW_ISIZE  = 4'd8;
  localparam logic [3:0] HW_XRES   = 4'd9;
  localparam logic [3:0] HW_YRES   = 4'd10;

  typedef struct packed {
    logic                is_hdr;
    logic                frame_end;
    logic [1:0]          pad;
    logic [7:0]          blue;
    logic [7:0]          green;
    logic [7:0]          red;
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
    logic [STRIDE_W-1:0] stride;
  } cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_MAX) begin
      r = DIM_W'(DIM_MAX);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [7:0] byte_of(input logic [WORD_W-1:0] word,
                                         input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0:    r = word[7:0];
      2'd1:    r = word[15:8];
      2'd2:    r = word[23:16];
      default: r = word[31:24];
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/bmpenc_intf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpenc channel interfaces
// Pixel/command input channel and byte output channel, valid/ready.
// ----------------------------------------------------------------------------
interface bmpenc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, action, red, green, blue, input ready);
  modport sink   (input valid, action, red, green, blue, output ready);
endinterface

interface bmpenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;
  modport source (output valid, out_byte, run_last, frame_end, input ready);
  modport sink   (input valid, out_byte, run_last, frame_end, output ready);
endinterface
`default_nettype wire

>>> src/bmpenc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpenc_front
// Config registers, frame tracking and command build for each input beat.
// ----------------------------------------------------------------------------
module bmpenc_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bmpenc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [bmpenc_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_action,
  input  wire logic [7:0]                      in_red,
  input  wire logic [7:0]                      in_green,
  input  wire logic [7:0]                      in_blue,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output bmpenc_pkg::cmd_t                     q_din
);

  logic [bmpenc_pkg::CFG_W-1:0] img_w_r, img_h_r;
  logic                         in_frame_r;
  logic [bmpenc_pkg::DIM_W-1:0] fw_r, fh_r, col_r, row_r;
  logic [bmpenc_pkg::DIM_W-1:0] cw, ch, col_inc, row_inc;
  logic                         start, pix, row_end, frm_end;

  always_comb begin
    cw       = bmpenc_pkg::clamp_dim(img_w_r);
    ch       = bmpenc_pkg::clamp_dim(img_h_r);
    col_inc  = col_r + bmpenc_pkg::DIM_W'(1);
    row_inc  = row_r + bmpenc_pkg::DIM_W'(1);
    row_end  = (col_inc == fw_r);
    frm_end  = row_end && (row_inc == fh_r);
    in_ready = !q_full;
    start    = in_valid && !q_full && !in_action;
    pix      = in_valid && !q_full && in_action && in_frame_r;
    q_push   = start || pix;

    q_din.is_hdr    = !in_action;
    q_din.frame_end = frm_end;
    q_din.pad       = row_end ? fw_r[1:0] : 2'd0;
    q_din.blue      = in_blue;
    q_din.green     = in_green;
    q_din.red       = in_red;
    q_din.w         = cw;
    q_din.h         = ch;
    q_din.stride    = bmpenc_pkg::STRIDE_W'(cw) + (bmpenc_pkg::STRIDE_W'(cw) << 1)
                    + bmpenc_pkg::STRIDE_W'(cw[1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= bmpenc_pkg::WIDTH_RST;
      img_h_r    <= bmpenc_pkg::HEIGHT_RST;
      in_frame_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      fw_r       <= '0;
      fh_r       <= '0;
    end else begin
      if (cfg_we && cfg_idx == bmpenc_pkg::CFG_IDX_WIDTH) begin
        img_w_r <= cfg_data;
      end
      if (cfg_we && cfg_idx == bmpenc_pkg::CFG_IDX_HEIGHT) begin
        img_h_r <= cfg_data;
      end
      if (start) begin
        in_frame_r <= 1'b1;
        col_r      <= '0;
        row_r      <= '0;
        fw_r       <= cw;
        fh_r       <= ch;
      end else if (pix) begin
        col_r <= row_end ? '0 : col_inc;
        if (row_end) begin
          row_r <= frm_end ? '0 : row_inc;
        end
        if (frm_end) begin
          in_frame_r <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/bmpenc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpenc_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module bmpenc_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire bmpenc_pkg::cmd_t din,
  output logic                  full,
  input  wire logic             pop,
  output bmpenc_pkg::cmd_t      dout,
  output logic                  empty
);

  bmpenc_pkg::cmd_t                mem_r [bmpenc_pkg::FIFO_DEPTH];
  logic [bmpenc_pkg::PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [bmpenc_pkg::CNT_W-1:0]    cnt_r;

  always_comb begin
    full  = (cnt_r == bmpenc_pkg::CNT_W'(bmpenc_pkg::FIFO_DEPTH));
    empty = (cnt_r == '0);
    dout  = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= din;
        wr_ptr_r        <= wr_ptr_r + bmpenc_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + bmpenc_pkg::PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + bmpenc_pkg::CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - bmpenc_pkg::CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/bmpenc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpenc_back
// Expands one command into header, pixel and pad bytes, one byte per beat.
// ----------------------------------------------------------------------------
module bmpenc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire bmpenc_pkg::cmd_t q_dout,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic                  run_last,
  output logic                  frame_end
);

  bmpenc_pkg::cmd_t                cur_r;
  logic                            cur_vld_r;
  logic [bmpenc_pkg::IDX_W-1:0]    idx_r;
  logic [bmpenc_pkg::WORD_W-1:0]   prod_r;
  logic                            out_vld_r, run_last_r, frame_end_r;
  logic [7:0]                      byte_r;

  logic                            adv, cur_last;
  logic [bmpenc_pkg::IDX_W-1:0]    last_idx, hofs;
  logic [bmpenc_pkg::WORD_W-1:0]   hword;
  logic [7:0]                      sel_byte;

  always_comb begin
    adv      = !out_vld_r || out_ready;
    last_idx = cur_r.is_hdr ? bmpenc_pkg::HDR_LAST
                            : bmpenc_pkg::PIX_LAST + bmpenc_pkg::IDX_W'(cur_r.pad);
    cur_last = (idx_r == last_idx);
    q_pop    = adv && (!cur_vld_r || cur_last) && !q_empty;

    hofs = idx_r - bmpenc_pkg::HDR_WORD0;
    case (hofs[bmpenc_pkg::IDX_W-1:2])
      bmpenc_pkg::HW_FSIZE:  hword = prod_r + bmpenc_pkg::WORD_W'(bmpenc_pkg::HDR_LEN);
      bmpenc_pkg::HW_OFFSET: hword = bmpenc_pkg::WORD_W'(bmpenc_pkg::HDR_LEN);
      bmpenc_pkg::HW_DIB:    hword = bmpenc_pkg::DIB_LEN;
      bmpenc_pkg::HW_WIDTH:  hword = bmpenc_pkg::WORD_W'(cur_r.w);
      bmpenc_pkg::HW_HEIGHT: hword = bmpenc_pkg::WORD_W'(cur_r.h);
      bmpenc_pkg::HW_PLANES: hword = bmpenc_pkg::PLANES_BPP;
      bmpenc_pkg::HW_ISIZE:  hword = prod_r;
      bmpenc_pkg::HW_XRES:   hword = bmpenc_pkg::PELS_PER_M;
      bmpenc_pkg::HW_YRES:   hword = bmpenc_pkg::PELS_PER_M;
      default:               hword = '0;
    endcase

    if (cur_r.is_hdr) begin
      case (idx_r)
        bmpenc_pkg::IDX_W'(0): sel_byte = bmpenc_pkg::SIG_B;
        bmpenc_pkg::IDX_W'(1): sel_byte = bmpenc_pkg::SIG_M;
        default:               sel_byte = bmpenc_pkg::byte_of(hword, hofs[1:0]);
      endcase
    end else begin
      case (idx_r)
        bmpenc_pkg::IDX_W'(0): sel_byte = cur_r.blue;
        bmpenc_pkg::IDX_W'(1): sel_byte = cur_r.green;
        bmpenc_pkg::IDX_W'(2): sel_byte = cur_r.red;
        default:               sel_byte = 8'd0;
      endcase
    end

    out_valid = out_vld_r;
    out_byte  = byte_r;
    run_last  = run_last_r;
    frame_end = frame_end_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= bmpenc_pkg::WORD_W'(cur_r.stride) * bmpenc_pkg::WORD_W'(cur_r.h);
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_r <= cur_vld_r;
        if (cur_vld_r) begin
          byte_r      <= sel_byte;
          run_last_r  <= cur_last;
          frame_end_r <= cur_last && !cur_r.is_hdr && cur_r.frame_end;
        end
      end
      if (q_pop) begin
        cur_r     <= q_dout;
        cur_vld_r <= 1'b1;
        idx_r     <= '0;
      end else if (adv && cur_vld_r) begin
        idx_r <= cur_last ? '0 : idx_r + bmpenc_pkg::IDX_W'(1);
        if (cur_last) begin
          cur_vld_r <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/bmp_24bit_stream_encoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_24bit_stream_encoder_unit
// Streams an uncompressed 24-bit BMP file, one byte per output beat.
//
// in_bus:  action 0 opens a frame and yields the 54-byte header for the
//          current cfg width/height; action 1 carries one pixel and yields
//          blue, green, red, plus zero pad bytes after the last pixel of a
//          row. Pixels outside a frame are taken and dropped.
// out_bus: out_byte with run_last on the last byte of each input beat and
//          frame_end on the final byte of the file.
// cfg:     cfg_we/cfg_idx/cfg_data, index 0 width, 1 height, write only.
// Path:    a taken beat passes the command queue, the back end's command register and its byte register.
// Rate:    one output byte per cycle from the back end's byte register while
//          out_bus is ready; a pixel yields 3 bytes (3 to 6 at a row end), a header 54.
//          A two-deep command queue lets the next beat enter meanwhile.
// Reset:   rst_n synchronous; frame closed, queue empty, width 640,
//          height 480. A stalled out_bus holds its byte and backs up into
//          the queue; in_bus.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module bmp_24bit_stream_encoder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bmpenc_in_if.sink                            in_bus,
  bmpenc_out_if.source                         out_bus,
  input  wire logic                            cfg_we,
  input  wire logic [bmpenc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [bmpenc_pkg::CFG_W-1:0]    cfg_data
);

  bmpenc_pkg::cmd_t q_din, q_dout;
  logic             q_push, q_pop, q_full, q_empty;

  bmpenc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_action (in_bus.action),
    .in_red    (in_bus.red),
    .in_green  (in_bus.green),
    .in_blue   (in_bus.blue),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  bmpenc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  bmpenc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_byte  (out_bus.out_byte),
    .run_last  (out_bus.run_last),
    .frame_end (out_bus.frame_end)
  );

endmodule
`default_nettype wire

>>> src/bmpenc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpenc_checker
// Port-level checks on the output channel of the encoder.
// ----------------------------------------------------------------------------
module bmpenc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       run_last,
  input wire logic       frame_end
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte))
    else $error("out byte changed while stalled");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> run_last)
    else $error("frame_end without run_last");

endmodule

bind bmp_24bit_stream_encoder_unit bmpenc_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_byte  (out_bus.out_byte),
  .run_last  (out_bus.run_last),
  .frame_end (out_bus.frame_end)
);
`default_nettype wire
